// ===== src/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned TermW = ElemW + 1;
  localparam int unsigned QuotW = 16;

  localparam logic [1:0] PivW = 2'd0;
  localparam logic [1:0] PivX = 2'd1;
  localparam logic [1:0] PivY = 2'd2;
  localparam logic [1:0] PivZ = 2'd3;

  typedef struct packed {
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m13;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
    logic signed [ElemW-1:0] m23;
    logic signed [ElemW-1:0] m31;
    logic signed [ElemW-1:0] m32;
    logic signed [ElemW-1:0] m33;
  } in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] quat_w;
    logic signed [ElemW-1:0] quat_x;
    logic signed [ElemW-1:0] quat_y;
    logic signed [ElemW-1:0] quat_z;
    logic [1:0]              pivot_index;
    logic                    bad_matrix;
  } out_t;

  // pivot choice and bad flag travel with every request
  typedef struct packed {
    logic [1:0] piv;
    logic       bad;
  } ctl_t;

endpackage

// ===== src/rmq_front.sv =====
// trace sums, pivot choice and off-diagonal term selection, one register stage
// depends on rmq_pkg
module rmq_front #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      stall_o,
  input  rmq_pkg::in_t                              in_i,
  output logic                                      valid_o,
  input  logic                                      stall_i,
  output logic [((FRAC_BITS > 17) ? FRAC_BITS : 17)+1:0] t_o,
  output rmq_pkg::ctl_t                             ctl_o,
  output logic [2:0][rmq_pkg::TermW-1:0]            terms_o
);

  localparam int unsigned TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned TermW = rmq_pkg::TermW;

  logic signed [TW-1:0] one, e11, e22, e33;
  logic signed [TW-1:0] t0, t1, t2, t3, best;
  logic signed [TermW-1:0] dwx, dwy, dwz, sxy, sxz, syz;
  logic [1:0] piv;
  logic bad;
  logic [TW-2:0] t_d;
  rmq_pkg::ctl_t ctl_d;
  logic [2:0][TermW-1:0] terms_d;

  logic valid_q;
  logic [TW-2:0] t_q;
  rmq_pkg::ctl_t ctl_q;
  logic [2:0][TermW-1:0] terms_q;
  logic adv;

  always_comb begin
    one = TW'(1) << FRAC_BITS;
    e11 = {{(TW-16){in_i.m11[15]}}, in_i.m11};
    e22 = {{(TW-16){in_i.m22[15]}}, in_i.m22};
    e33 = {{(TW-16){in_i.m33[15]}}, in_i.m33};
    t0 = one + e11 + e22 + e33;
    t1 = one + e11 - e22 - e33;
    t2 = one - e11 + e22 - e33;
    t3 = one - e11 - e22 + e33;
    dwx = {in_i.m32[15], in_i.m32} - {in_i.m23[15], in_i.m23};
    dwy = {in_i.m13[15], in_i.m13} - {in_i.m31[15], in_i.m31};
    dwz = {in_i.m21[15], in_i.m21} - {in_i.m12[15], in_i.m12};
    sxy = {in_i.m12[15], in_i.m12} + {in_i.m21[15], in_i.m21};
    sxz = {in_i.m13[15], in_i.m13} + {in_i.m31[15], in_i.m31};
    syz = {in_i.m23[15], in_i.m23} + {in_i.m32[15], in_i.m32};
    // largest estimate, first on ties
    piv = rmq_pkg::PivW;
    best = t0;
    if (t1 > best) begin
      piv = rmq_pkg::PivX;
      best = t1;
    end
    if (t2 > best) begin
      piv = rmq_pkg::PivY;
      best = t2;
    end
    if (t3 > best) begin
      piv = rmq_pkg::PivZ;
      best = t3;
    end
    bad = best[TW-1] || (best == '0);
    unique case (piv)
      rmq_pkg::PivW: terms_d = {dwz, dwy, dwx};
      rmq_pkg::PivX: terms_d = {sxz, sxy, dwx};
      rmq_pkg::PivY: terms_d = {syz, sxy, dwy};
      default:       terms_d = {syz, sxz, dwz};
    endcase
    if (bad) begin
      t_d = '0;
      ctl_d.piv = rmq_pkg::PivW;
      terms_d = '0;
    end else begin
      t_d = best[TW-2:0];
      ctl_d.piv = piv;
    end
    ctl_d.bad = bad;
  end

  assign adv = !valid_q || !stall_i;
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q <= t_d;
      ctl_q <= ctl_d;
      terms_q <= terms_d;
    end
  end

  assign valid_o = valid_q;
  assign t_o = t_q;
  assign ctl_o = ctl_q;
  assign terms_o = terms_q;

endmodule

// ===== src/rmq_sqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on rmq_pkg
module rmq_sqrt #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [((FRAC_BITS > 17) ? FRAC_BITS : 17)+1:0] t_i,
  input  rmq_pkg::ctl_t                      ctl_i,
  input  logic [2:0][rmq_pkg::TermW-1:0]     terms_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [(((((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2 + FRAC_BITS) + 1) / 2)-1:0] s_o,
  output rmq_pkg::ctl_t                      ctl_o,
  output logic [2:0][rmq_pkg::TermW-1:0]     terms_o
);

  localparam int unsigned TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned RW0 = TW - 1 + FRAC_BITS;
  localparam int unsigned SW  = (RW0 + 1) / 2;
  localparam int unsigned RW  = 2 * SW;
  localparam int unsigned RMW = SW + 3;

  logic                             v    [0:SW];
  logic                             st   [0:SW];
  logic [RW-1:0]                    rad  [0:SW];
  logic [RMW-1:0]                   rem  [0:SW];
  logic [SW-1:0]                    root [0:SW];
  rmq_pkg::ctl_t                    ctl  [0:SW];
  logic [2:0][rmq_pkg::TermW-1:0]   tm   [0:SW];

  assign v[0]    = valid_i;
  assign rad[0]  = RW'(t_i) << FRAC_BITS;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign ctl[0]  = ctl_i;
  assign tm[0]   = terms_i;
  assign st[SW]  = stall_i;
  assign stall_o = st[0];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic adv;
    logic [RMW-1:0] cur, trial, rem_d;
    logic [SW-1:0] root_d;
    logic ge;

    assign adv   = !st[k];
    assign st[k] = v[k+1] && st[k+1];

    always_comb begin
      cur    = {rem[k][RMW-3:0], rad[k][RW-1-2*k -: 2]};
      trial  = RMW'({root[k], 2'b01});
      ge     = cur >= trial;
      rem_d  = ge ? cur - trial : cur;
      root_d = {root[k][SW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad[k+1]  <= rad[k];
        rem[k+1]  <= rem_d;
        root[k+1] <= root_d;
        ctl[k+1]  <= ctl[k];
        tm[k+1]   <= tm[k];
      end
    end
  end

  assign valid_o = v[SW];
  assign s_o     = root[SW];
  assign ctl_o   = ctl[SW];
  assign terms_o = tm[SW];

endmodule

// ===== src/rmq_div.sv =====
// three-lane pipelined rounding divider by 4*p, saturation and output placement
// depends on rmq_pkg
module rmq_div #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [(((((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2 + FRAC_BITS) + 1) / 2)-1:0] s_i,
  input  rmq_pkg::ctl_t                      ctl_i,
  input  logic [2:0][rmq_pkg::TermW-1:0]     terms_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output rmq_pkg::out_t                      out_o
);

  localparam int unsigned TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned RW0 = TW - 1 + FRAC_BITS;
  localparam int unsigned SW  = (RW0 + 1) / 2;
  localparam int unsigned DW  = SW + 2;
  localparam int unsigned QW  = rmq_pkg::QuotW;
  localparam int unsigned NW  = ((rmq_pkg::ElemW + FRAC_BITS > DW + QW) ?
                                 (rmq_pkg::ElemW + FRAC_BITS) : (DW + QW)) + 1;
  // round, scale, overflow check, then one quotient bit per stage
  localparam int unsigned ND  = QW + 3;

  logic                     v    [0:ND];
  logic                     st   [0:ND];
  rmq_pkg::ctl_t            ctl  [0:ND];
  logic [SW-1:0]            p    [0:ND];
  logic [DW-1:0]            d    [0:ND];
  logic [2:0][NW-1:0]       rem  [0:ND];
  logic [2:0][QW-1:0]       q    [0:ND];
  logic [2:0]               neg  [0:ND];
  logic [2:0]               ovf  [0:ND];

  assign v[0]   = valid_i;
  assign ctl[0] = ctl_i;
  assign p[0]   = s_i;
  assign d[0]   = '0;
  assign q[0]   = '0;
  assign neg[0] = '0;
  assign ovf[0] = '0;
  for (genvar l = 0; l < 3; l++) begin : g_ext
    assign rem[0][l] = {{(NW-rmq_pkg::TermW){terms_i[l][rmq_pkg::TermW-1]}}, terms_i[l]};
  end
  assign stall_o = st[0];

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic adv;
    logic [SW-1:0] p_d;
    logic [DW-1:0] d_d;
    logic [2:0][NW-1:0] rem_d;
    logic [2:0][QW-1:0] q_d;
    logic [2:0] neg_d, ovf_d;

    assign adv   = !st[k];
    assign st[k] = v[k+1] && st[k+1];

    if (k == 0) begin : g_round
      // pivot p = (root + 1) / 2, divisor 4p, term magnitudes
      always_comb begin
        p_d   = SW'(({1'b0, p[k]} + (SW+1)'(1)) >> 1);
        d_d   = {p_d, 2'b00};
        q_d   = q[k];
        ovf_d = ovf[k];
        for (int l = 0; l < 3; l++) begin
          neg_d[l] = rem[k][l][NW-1];
          rem_d[l] = neg_d[l] ? (~rem[k][l] + NW'(1)) : rem[k][l];
        end
      end
    end else if (k == 1) begin : g_scale
      // numerator mag * 2^frac + 2p rounds to nearest
      always_comb begin
        p_d   = p[k];
        d_d   = d[k];
        q_d   = q[k];
        neg_d = neg[k];
        ovf_d = ovf[k];
        for (int l = 0; l < 3; l++) begin
          rem_d[l] = (rem[k][l] << FRAC_BITS) + NW'({p[k], 1'b0});
        end
      end
    end else if (k == 2) begin : g_ovf
      always_comb begin
        p_d   = p[k];
        d_d   = d[k];
        q_d   = q[k];
        neg_d = neg[k];
        rem_d = rem[k];
        for (int l = 0; l < 3; l++) begin
          ovf_d[l] = rem[k][l] >= (NW'(d[k]) << QW);
        end
      end
    end else begin : g_bit
      localparam int unsigned J = ND - 1 - k;
      logic [NW-1:0] dj;
      always_comb begin
        p_d   = p[k];
        d_d   = d[k];
        neg_d = neg[k];
        ovf_d = ovf[k];
        dj    = NW'(d[k]) << J;
        for (int l = 0; l < 3; l++) begin
          q_d[l]   = q[k][l];
          rem_d[l] = rem[k][l];
          if (rem[k][l] >= dj) begin
            rem_d[l]  = rem[k][l] - dj;
            q_d[l][J] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctl[k+1] <= ctl[k];
        p[k+1]   <= p_d;
        d[k+1]   <= d_d;
        rem[k+1] <= rem_d;
        q[k+1]   <= q_d;
        neg[k+1] <= neg_d;
        ovf[k+1] <= ovf_d;
      end
    end
  end

  // output register
  logic valid_q, adv_out;
  rmq_pkg::out_t out_q, out_d;
  logic [2:0][15:0] lane;
  logic [15:0] pv;

  assign adv_out = !valid_q || !stall_i;
  assign st[ND]  = valid_q && stall_i;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!neg[ND][l]) begin
        lane[l] = (ovf[ND][l] || q[ND][l] > QW'(32767)) ? 16'h7fff : 16'(q[ND][l]);
      end else begin
        lane[l] = (ovf[ND][l] || q[ND][l] > QW'(32768)) ? 16'h8000
                  : (~16'(q[ND][l]) + 16'd1);
      end
    end
    pv = (32'(p[ND]) > 32'd32767) ? 16'h7fff : 16'(p[ND]);
    out_d.pivot_index = ctl[ND].piv;
    out_d.bad_matrix  = ctl[ND].bad;
    unique case (ctl[ND].piv)
      rmq_pkg::PivW: begin
        out_d.quat_w = pv;      out_d.quat_x = lane[0];
        out_d.quat_y = lane[1]; out_d.quat_z = lane[2];
      end
      rmq_pkg::PivX: begin
        out_d.quat_w = lane[0]; out_d.quat_x = pv;
        out_d.quat_y = lane[1]; out_d.quat_z = lane[2];
      end
      rmq_pkg::PivY: begin
        out_d.quat_w = lane[0]; out_d.quat_x = lane[1];
        out_d.quat_y = pv;      out_d.quat_z = lane[2];
      end
      default: begin
        out_d.quat_w = lane[0]; out_d.quat_x = lane[1];
        out_d.quat_y = lane[2]; out_d.quat_z = pv;
      end
    endcase
    if (ctl[ND].bad) begin
      out_d.quat_w = '0;
      out_d.quat_x = '0;
      out_d.quat_y = '0;
      out_d.quat_z = '0;
      out_d.pivot_index = rmq_pkg::PivW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_out) begin
      valid_q <= v[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ===== src/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion (Shepperd's method), usage notes:
// - input channel: in_valid_i / in_stall_o carry one 3x3 matrix request (in_t,
//   nine signed elements with FRAC_BITS fraction bits); accepted on a rising
//   edge with in_valid_i high and in_stall_o low
// - output channel: out_valid_o / out_stall_i carry one out_t result per
//   request: quaternion w x y z, pivot_index and bad_matrix
// - throughput: one request per cycle while out_stall_i is low; every stage
//   holds its own valid bit. Pipeline: front register, square-root stages
//   (one root bit per stage), divider stages (one quotient bit per stage),
//   output register; root width ceil((max(FRAC_BITS,17)+2+FRAC_BITS)/2)
// - stall: a stalled result holds in the output register; empty stages keep
//   filling, so in_stall_o rises only once the whole pipe is full
// - reset: asynchronous, clears every valid bit; no clearing pass, ready to
//   take a request as soon as reset is released
// - bad matrix: when no trace estimate is positive the quaternion and
//   pivot_index come out zero and bad_matrix is set
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmq_pkg::out_t out_o
);

  localparam int unsigned TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned RW0 = TW - 1 + FRAC_BITS;
  localparam int unsigned SW  = (RW0 + 1) / 2;

  // front stage to square root
  logic                             f_valid, f_stall;
  logic [TW-2:0]                    f_t;
  rmq_pkg::ctl_t                    f_ctl;
  logic [2:0][rmq_pkg::TermW-1:0]   f_terms;

  // square root to divider
  logic                             s_valid, s_stall;
  logic [SW-1:0]                    s_root;
  rmq_pkg::ctl_t                    s_ctl;
  logic [2:0][rmq_pkg::TermW-1:0]   s_terms;

  // trace estimates, pivot and the three terms for the other components
  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .in_i    (in_i),
    .valid_o (f_valid),
    .stall_i (f_stall),
    .t_o     (f_t),
    .ctl_o   (f_ctl),
    .terms_o (f_terms)
  );

  // floor sqrt of the pivot estimate scaled by 2^FRAC_BITS
  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .stall_o (f_stall),
    .t_i     (f_t),
    .ctl_i   (f_ctl),
    .terms_i (f_terms),
    .valid_o (s_valid),
    .stall_i (s_stall),
    .s_o     (s_root),
    .ctl_o   (s_ctl),
    .terms_o (s_terms)
  );

  // pivot rounding, three rounded divisions, saturation, output register
  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .stall_o (s_stall),
    .s_i     (s_root),
    .ctl_i   (s_ctl),
    .terms_i (s_terms),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .out_o   (out_o)
  );

endmodule
